### rtl/assert_macros.svh
// assertion macros for the ringtone note token parser
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RTNP_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed")
`define RTNP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed")
`else
`define RTNP_ASSERT(lbl, cond)
`define RTNP_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

### rtl/rtnp_pkg.sv
// types, constants and lookup functions shared by the note parser
`default_nettype none
package rtnp_pkg;

    localparam logic [3:0] NOTE_PAUSE  = 4'd12;
    localparam logic [3:0] NO_NOTE     = 4'd15;
    localparam logic [7:0] CHAR_SPACE  = 8'h20;
    localparam logic [7:0] CHAR_DOT    = 8'h2E;
    localparam logic [7:0] CHAR_DASH   = 8'h2D;
    localparam logic [7:0] CHAR_SHARP  = 8'h23;
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_ONE    = 8'h31;
    localparam logic [7:0] CHAR_FIVE   = 8'h35;
    localparam logic [7:0] CHAR_NINE   = 8'h39;
    localparam int         QUEUE_DEPTH = 2;
    localparam int         TDATA_W     = 64;
    localparam int         TUSER_W     = 2;

    typedef struct packed {
        logic [3:0]  note;
        logic [2:0]  octave;
        logic [15:0] length;
        logic        dotted;
        logic        bad;
        logic [15:0] count;
        logic        last;
    } token_t;

    function automatic logic [3:0] plain_letter(input logic [7:0] c);
        logic [3:0] n;
        case (c | 8'h20)
            8'h63:   n = 4'd0;
            8'h64:   n = 4'd2;
            8'h65:   n = 4'd4;
            8'h66:   n = 4'd5;
            8'h67:   n = 4'd7;
            8'h61:   n = 4'd9;
            8'h62:   n = 4'd11;
            8'h68:   n = 4'd11;
            default: n = NO_NOTE;
        endcase
        return n;
    endfunction

    function automatic logic [3:0] sharp_letter(input logic [7:0] c);
        logic [3:0] n;
        case (c | 8'h20)
            8'h63:   n = 4'd1;
            8'h64:   n = 4'd3;
            8'h65:   n = 4'd5;
            8'h66:   n = 4'd6;
            8'h67:   n = 4'd8;
            8'h61:   n = 4'd10;
            default: n = NO_NOTE;
        endcase
        return n;
    endfunction

    // small octave row, then first octave row shifted up for the higher ones
    function automatic logic [19:0] freq_lookup(input logic [3:0] note, input logic [2:0] oct);
        logic [19:0] row0;
        logic [19:0] row1;
        logic [19:0] f;
        case (note)
            4'd0:    begin row0 = 20'd13082; row1 = 20'd26163; end
            4'd1:    begin row0 = 20'd13859; row1 = 20'd27718; end
            4'd2:    begin row0 = 20'd14683; row1 = 20'd29366; end
            4'd3:    begin row0 = 20'd15556; row1 = 20'd31113; end
            4'd4:    begin row0 = 20'd16482; row1 = 20'd32963; end
            4'd5:    begin row0 = 20'd17462; row1 = 20'd34923; end
            4'd6:    begin row0 = 20'd18500; row1 = 20'd36999; end
            4'd7:    begin row0 = 20'd19600; row1 = 20'd39200; end
            4'd8:    begin row0 = 20'd20765; row1 = 20'd41530; end
            4'd9:    begin row0 = 20'd22000; row1 = 20'd44000; end
            4'd10:   begin row0 = 20'd23308; row1 = 20'd46616; end
            4'd11:   begin row0 = 20'd24694; row1 = 20'd49388; end
            default: begin row0 = 20'd0;     row1 = 20'd0;     end
        endcase
        if (oct > 3'd5)
        begin
            f = 20'd0;
        end
        else if (oct == 3'd0)
        begin
            f = row0;
        end
        else
        begin
            f = row1 << (oct - 3'd1);
        end
        return f;
    endfunction

endpackage
`default_nettype wire

### rtl/ringtone_note_token_parser_top.sv
// top level of the ringtone note token parser
`default_nettype none
`include "assert_macros.svh"
// Parses ringtone melody text one character a word and gives one note word
// per token (space-separated, or closed by the character marked tlast).
// Characters are taken one per cycle while the two-entry token queue has
// room; each note then passes through the note unit: a pop, the bit-serial
// division of beat_ticks by the note length, and a load of the output
// register, which waits while the previous output word waits on m_tready.
// s_tready drops whenever the queue is full. beat_ticks may only be written
// while no note is in flight.
module ringtone_note_token_parser_top
    import rtnp_pkg::*;
#(
    parameter int MAX_TOKEN = 9
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [15:0]        cfg_data,      // beat_ticks
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [7:0]         s_tdata,       // char_byte
    input  wire logic               s_tlast,       // last_char
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,       // note_index, octave_index,
                                                   // duration_ticks, freq_centihz,
                                                   // note_count, zero fill
    output logic [TUSER_W-1:0]      m_tuser,       // is_pause, bad_token
    output logic                    m_tlast        // melody_end
);

    logic [15:0] beat_reg;
    logic        char_take;
    logic        push;
    token_t      push_data;
    logic        queue_full;
    logic        pop_valid;
    token_t      pop_data;
    logic        pop;

    assign cfg_ready = 1'b1;
    assign s_tready  = !queue_full;
    assign char_take = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= 16'd1000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            beat_reg <= cfg_data;
        end
    end

    rtnp_front #(
        .MAX_TOKEN (MAX_TOKEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_take),
        .char_byte  (s_tdata),
        .last_char  (s_tlast),
        .push_data  (push_data),
        .push       (push)
    );

    rtnp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop_valid (pop_valid),
        .pop_data  (pop_data),
        .pop       (pop)
    );

    rtnp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_ticks (beat_reg),
        .q_valid    (pop_valid),
        .q_data     (pop_data),
        .q_pop      (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

    // queue overflow and underflow
    `RTNP_ASSERT(a_no_push_full, !(push && queue_full));
    `RTNP_ASSERT(a_no_pop_empty, !(pop && !pop_valid));
    // rests carry no frequency and the pause flag agrees with the note code
    `RTNP_ASSERT_IMP(a_pause_freq, m_tvalid && m_tuser[0], m_tdata[42:23] == 20'd0);
    `RTNP_ASSERT_IMP(a_pause_code, m_tvalid, m_tuser[0] == (m_tdata[3:0] == NOTE_PAUSE));

endmodule
`default_nettype wire

### rtl/rtnp_front.sv
// character parser: tracks token state and queues one entry per finished token
`default_nettype none
module rtnp_front
    import rtnp_pkg::*;
#(
    parameter int MAX_TOKEN = 9
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       char_valid,
    input  wire logic [7:0] char_byte,
    input  wire logic       last_char,
    output token_t          push_data,
    output logic            push
);

    localparam int TW = $clog2(MAX_TOKEN + 1);

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_DIGITS = 3'd1;
    localparam logic [2:0] PH_LETTER = 3'd2;
    localparam logic [2:0] PH_SHARP  = 3'd3;
    localparam logic [2:0] PH_OCTAVE = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;
    localparam logic [2:0] PH_LONG   = 3'd6;

    logic [2:0]    phase_reg, phase_next;
    logic [15:0]   len_reg, len_next;
    logic          dot_reg, dot_next;
    logic [3:0]    note_reg, note_next;
    logic [2:0]    oct_reg, oct_next;
    logic [TW-1:0] chars_reg, chars_next;
    logic [15:0]   count_reg, count_next;

    always_comb
    begin
        logic        non_space;
        logic        is_digit;
        logic        letter_slot;
        logic [19:0] len_x10;
        logic [3:0]  n;
        logic        emit;
        logic [15:0] count_inc;
        logic        long_tok;

        non_space   = (char_byte != CHAR_SPACE);
        is_digit    = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
        letter_slot = 1'b0;
        len_x10     = 20'd0;
        n           = NO_NOTE;
        emit        = 1'b0;
        count_inc   = 16'd0;
        long_tok    = 1'b0;

        phase_next = phase_reg;
        len_next   = len_reg;
        dot_next   = dot_reg;
        note_next  = note_reg;
        oct_next   = oct_reg;
        chars_next = chars_reg;
        count_next = count_reg;
        push       = 1'b0;

        if (char_valid)
        begin
            if (non_space)
            begin
                if (phase_next == PH_IDLE)
                begin
                    phase_next = PH_DIGITS;
                    len_next   = 16'd0;
                    dot_next   = 1'b0;
                    chars_next = '0;
                end
                if (phase_next != PH_LONG)
                begin
                    if (chars_next >= TW'(MAX_TOKEN))
                    begin
                        phase_next = PH_LONG;
                    end
                    else
                    begin
                        chars_next = chars_next + 1'b1;
                        case (phase_next)
                            PH_DIGITS:
                            begin
                                if (is_digit)
                                begin
                                    len_x10 = {1'b0, len_next, 3'b0} + {3'b0, len_next, 1'b0}
                                              + {16'd0, char_byte[3:0]};
                                    len_next = (len_x10 > 20'd65535) ? 16'hFFFF : len_x10[15:0];
                                end
                                else if (char_byte == CHAR_DOT)
                                begin
                                    dot_next   = 1'b1;
                                    phase_next = PH_LETTER;
                                end
                                else
                                begin
                                    letter_slot = 1'b1;
                                end
                            end
                            PH_LETTER:
                            begin
                                letter_slot = 1'b1;
                            end
                            PH_SHARP:
                            begin
                                n = sharp_letter(char_byte);
                                if (n != NO_NOTE)
                                begin
                                    note_next = n;
                                end
                                phase_next = PH_OCTAVE;
                            end
                            PH_OCTAVE:
                            begin
                                if ((char_byte >= CHAR_ONE) && (char_byte <= CHAR_FIVE))
                                begin
                                    oct_next = char_byte[2:0];
                                end
                                phase_next = PH_DONE;
                            end
                            default:
                            begin
                            end
                        endcase
                        if (letter_slot)
                        begin
                            if (char_byte == CHAR_DASH)
                            begin
                                note_next  = NOTE_PAUSE;
                                oct_next   = 3'd1;
                                phase_next = PH_DONE;
                            end
                            else if (char_byte == CHAR_SHARP)
                            begin
                                phase_next = PH_SHARP;
                            end
                            else
                            begin
                                n = plain_letter(char_byte);
                                if (n != NO_NOTE)
                                begin
                                    note_next = n;
                                end
                                phase_next = PH_OCTAVE;
                            end
                        end
                    end
                end
            end

            long_tok  = (phase_next == PH_LONG);
            emit      = (!non_space || last_char) && (phase_next != PH_IDLE);
            count_inc = (count_reg == 16'hFFFF) ? count_reg : count_reg + 16'd1;
            if (emit)
            begin
                push       = 1'b1;
                count_next = count_inc;
                phase_next = PH_IDLE;
            end
            if (last_char)
            begin
                count_next = 16'd0;
            end
        end

        push_data.note   = note_next;
        push_data.octave = oct_next;
        push_data.length = len_next;
        push_data.dotted = dot_next;
        push_data.bad    = long_tok || (len_next == 16'd0);
        push_data.count  = count_inc;
        push_data.last   = last_char;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            len_reg   <= 16'd0;
            dot_reg   <= 1'b0;
            note_reg  <= NOTE_PAUSE;
            oct_reg   <= 3'd1;
            chars_reg <= '0;
            count_reg <= 16'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            dot_reg   <= dot_next;
            note_reg  <= note_next;
            oct_reg   <= oct_next;
            chars_reg <= chars_next;
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

### rtl/rtnp_queue.sv
// short token queue between the parser and the note unit
`default_nettype none
module rtnp_queue
    import rtnp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  token_t    push_data,
    output logic      full,
    output logic      pop_valid,
    output token_t    pop_data,
    input  wire logic pop
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    token_t        entry_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;

    assign full      = (fill_reg == CW'(QUEUE_DEPTH));
    assign pop_valid = (fill_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule
`default_nettype wire

### rtl/rtnp_back.sv
// note unit: bit-serial duration divide, frequency lookup and output register
`default_nettype none
module rtnp_back
    import rtnp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [15:0]        beat_ticks,
    input  wire logic               q_valid,
    input  token_t                  q_data,
    output logic                    q_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,
    output logic [TUSER_W-1:0]      m_tuser,
    output logic                    m_tlast
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;

    logic [1:0]          state_reg, state_next;
    token_t              tok_reg;
    logic [15:0]         rem_reg, rem_next;
    logic [15:0]         quo_reg, quo_next;
    logic [3:0]          cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0]  out_data_reg;
    logic [TUSER_W-1:0]  out_user_reg;
    logic                out_last_reg;
    logic                load;
    logic [16:0]         trial;
    logic [16:0]         dur_sum;
    logic [15:0]         dur;
    logic [19:0]         freq;

    assign trial   = {rem_reg, quo_reg[15]};
    assign dur_sum = {1'b0, quo_reg}
                     + (tok_reg.dotted ? {6'd0, beat_ticks[15:5]} : 17'd0);
    assign dur     = (tok_reg.length == 16'd0) ? 16'd0 :
                     (dur_sum[16] ? 16'hFFFF : dur_sum[15:0]);
    assign freq    = freq_lookup(tok_reg.note, tok_reg.octave);
    assign load    = (state_reg == ST_LOAD) && (!out_valid_reg || m_tready);

    always_comb
    begin
        state_next     = state_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        q_pop          = 1'b0;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    rem_next   = 16'd0;
                    quo_next   = beat_ticks;
                    cnt_next   = 4'd0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                // one quotient bit a cycle, msb first
                if (trial >= {1'b0, tok_reg.length})
                begin
                    rem_next = 16'(trial - {1'b0, tok_reg.length});
                    quo_next = {quo_reg[14:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[15:0];
                    quo_next = {quo_reg[14:0], 1'b0};
                end
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg == 4'd15)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            tok_reg <= q_data;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (load)
        begin
            out_data_reg <= {5'd0, tok_reg.count, freq, dur, tok_reg.octave, tok_reg.note};
            out_user_reg <= {tok_reg.bad, (tok_reg.note == NOTE_PAUSE)};
            out_last_reg <= tok_reg.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

### tb/sv/tb_ringtone_note_token_parser_top.sv
// testbench for the ringtone note token parser: directed and random melody text, checked per note
`timescale 1ns / 100ps
module tb_ringtone_note_token_parser_top;
    import rtnp_pkg::*;

    localparam int TOKEN_MAX = 9;
    localparam int SETTLE_CYCLES = 64;
    localparam int unsigned SMALL_OCTAVE_CHZ [12] = '{13082, 13859, 14683, 15556, 16482,
        17462, 18500, 19600, 20765, 22000, 23308, 24694};
    localparam int unsigned FIRST_OCTAVE_CHZ [12] = '{26163, 27718, 29366, 31113, 32963,
        34923, 36999, 39200, 41530, 44000, 46616, 49388};

    typedef enum int {
        TOK_IDLE,
        TOK_LENGTH,
        TOK_LETTER,
        TOK_SHARP,
        TOK_OCTAVE,
        TOK_DONE,
        TOK_LONG
    } token_phase_e;

    typedef struct {
        logic [3:0]  note;
        logic [2:0]  octave;
        logic        pause;
        logic [15:0] duration;
        logic [19:0] freq;
        logic [15:0] count;
        logic        bad;
        logic        melody_end;
    } note_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [15:0]        cfg_data = '0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata = '0;      // char_byte
    logic               s_tlast = 1'b0;    // last_char
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;           // note_index, octave_index, duration_ticks,
                                           // freq_centihz, note_count, zero fill
    logic [TUSER_W-1:0] m_tuser;           // is_pause, bad_token
    logic               m_tlast;           // melody_end

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int mismatch_count = 0;

    // predictor state
    logic [15:0]   beat_setting = 16'd1000;
    token_phase_e  tok_phase = TOK_IDLE;
    int unsigned   tok_length = 0;
    logic          tok_dotted = 1'b0;
    int unsigned   tok_chars = 0;
    logic [3:0]    cur_note = NOTE_PAUSE;
    logic [2:0]    cur_octave = 3'd1;
    int unsigned   melody_notes = 0;

    note_word_t    expected_notes [$];
    logic [7:0]    token_text [$];

    ringtone_note_token_parser_top #(
        .MAX_TOKEN (TOKEN_MAX)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [3:0] letter_note(input logic [7:0] ch, input logic sharp);
        logic [3:0] n;
        n = NO_NOTE;
        case (ch | 8'h20)
            "c": n = sharp ? 4'd1 : 4'd0;
            "d": n = sharp ? 4'd3 : 4'd2;
            "e": n = sharp ? 4'd5 : 4'd4;
            "f": n = sharp ? 4'd6 : 4'd5;
            "g": n = sharp ? 4'd8 : 4'd7;
            "a": n = sharp ? 4'd10 : 4'd9;
            "b", "h": n = sharp ? NO_NOTE : 4'd11;
            default: n = NO_NOTE;
        endcase
        return n;
    endfunction

    function automatic logic [19:0] note_freq(input logic [3:0] n, input logic [2:0] oct);
        if (n >= NOTE_PAUSE || oct > 3'd5)
            return 20'd0;
        if (oct == 3'd0)
            return 20'(SMALL_OCTAVE_CHZ[n]);
        return 20'(FIRST_OCTAVE_CHZ[n] << (oct - 3'd1));
    endfunction

    task automatic take_token_char(input logic [7:0] ch);
        logic        letter_slot;
        logic [3:0]  n;
        int unsigned v;
        letter_slot = 1'b0;
        if (tok_phase == TOK_LONG)
            return;
        if (tok_chars >= TOKEN_MAX)
        begin
            tok_phase = TOK_LONG;
            return;
        end
        tok_chars++;
        case (tok_phase)
            TOK_LENGTH:
            begin
                if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
                begin
                    v = tok_length * 10 + (ch - CHAR_ZERO);
                    tok_length = (v > 65535) ? 65535 : v;
                end
                else if (ch == CHAR_DOT)
                begin
                    tok_dotted = 1'b1;
                    tok_phase = TOK_LETTER;
                end
                else
                begin
                    letter_slot = 1'b1;
                end
            end
            TOK_LETTER:
                letter_slot = 1'b1;
            TOK_SHARP:
            begin
                n = letter_note(ch, 1'b1);
                if (n != NO_NOTE)
                    cur_note = n;
                tok_phase = TOK_OCTAVE;
            end
            TOK_OCTAVE:
            begin
                if (ch >= CHAR_ONE && ch <= CHAR_FIVE)
                    cur_octave = 3'(ch - CHAR_ZERO);
                tok_phase = TOK_DONE;
            end
            default:
                ;
        endcase
        if (letter_slot)
        begin
            if (ch == CHAR_DASH)
            begin
                cur_note = NOTE_PAUSE;
                cur_octave = 3'd1;
                tok_phase = TOK_DONE;
            end
            else if (ch == CHAR_SHARP)
            begin
                tok_phase = TOK_SHARP;
            end
            else
            begin
                n = letter_note(ch, 1'b0);
                if (n != NO_NOTE)
                    cur_note = n;
                tok_phase = TOK_OCTAVE;
            end
        end
    endtask

    task automatic predict_note(input logic [7:0] ch, input logic last);
        note_word_t  w;
        int unsigned d;
        if (ch != CHAR_SPACE)
        begin
            if (tok_phase == TOK_IDLE)
            begin
                tok_phase = TOK_LENGTH;
                tok_length = 0;
                tok_dotted = 1'b0;
                tok_chars = 0;
            end
            take_token_char(ch);
        end
        if ((ch == CHAR_SPACE || last) && tok_phase != TOK_IDLE)
        begin
            d = 0;
            if (tok_length != 0)
            begin
                d = beat_setting / tok_length;
                if (tok_dotted)
                    d += beat_setting / 32;
                if (d > 65535)
                    d = 65535;
            end
            if (melody_notes < 65535)
                melody_notes++;
            w.note = cur_note;
            w.octave = cur_octave;
            w.pause = (cur_note == NOTE_PAUSE);
            w.duration = 16'(d);
            w.freq = note_freq(cur_note, cur_octave);
            w.count = 16'(melody_notes);
            w.bad = (tok_phase == TOK_LONG) || (tok_length == 0);
            w.melody_end = last;
            expected_notes.push_back(w);
            tok_phase = TOK_IDLE;
        end
        if (last)
            melody_notes = 0;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic check_note_word();
        note_word_t w;
        if (expected_notes.size() == 0)
        begin
            report_mismatch("note word with none expected, tdata low bits", m_tdata[31:0], 0);
            return;
        end
        w = expected_notes.pop_front();
        if (m_tdata[3:0] !== w.note)
            report_mismatch("note_index", m_tdata[3:0], w.note);
        if (m_tdata[6:4] !== w.octave)
            report_mismatch("octave_index", m_tdata[6:4], w.octave);
        if (m_tdata[22:7] !== w.duration)
            report_mismatch("duration_ticks", m_tdata[22:7], w.duration);
        if (m_tdata[42:23] !== w.freq)
            report_mismatch("freq_centihz", m_tdata[42:23], w.freq);
        if (m_tdata[58:43] !== w.count)
            report_mismatch("note_count", m_tdata[58:43], w.count);
        if (m_tuser[0] !== w.pause)
            report_mismatch("is_pause", m_tuser[0], w.pause);
        if (m_tuser[1] !== w.bad)
            report_mismatch("bad_token", m_tuser[1], w.bad);
        if (m_tlast !== w.melody_end)
            report_mismatch("melody_end", m_tlast, w.melody_end);
    endtask

    // note word checker and receiver back-pressure
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            check_note_word();
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic send_char(input logic [7:0] ch, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= ch;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        predict_note(ch, last);
    endtask

    task automatic send_text(input string text, input logic last_on_final);
        for (int i = 0; i < text.len(); i++)
            send_char(text[i], last_on_final && (i == text.len() - 1));
    endtask

    task automatic write_beat(input logic [15:0] beat);
        s_tvalid <= 1'b0;
        while (expected_notes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= beat;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        beat_setting = beat;
    endtask

    task automatic push_number(input int unsigned value);
        string s;
        s = $sformatf("%0d", value);
        for (int i = 0; i < s.len(); i++)
            token_text.push_back(s[i]);
    endtask

    task automatic build_token();
        string letters;
        int    kind;
        int    n;
        letters = "cdefgabhCDEFGABH";
        token_text.delete();
        kind = $urandom_range(99);
        if (kind < 80)
        begin
            if ($urandom_range(9) == 0)
                token_text.push_back(CHAR_ZERO);
            case ($urandom_range(3))
                0: push_number(1 << $urandom_range(5));
                1: push_number($urandom_range(9));
                2: push_number($urandom_range(999));
                default: push_number($urandom_range(99999));
            endcase
            if ($urandom_range(9) < 3)
                token_text.push_back(CHAR_DOT);
            if ($urandom_range(99) < 15)
            begin
                token_text.push_back(CHAR_DASH);
            end
            else
            begin
                if ($urandom_range(99) < 35)
                    token_text.push_back(CHAR_SHARP);
                if ($urandom_range(19) == 0)
                    token_text.push_back(8'($urandom_range(255)));
                else
                    token_text.push_back(letters[$urandom_range(15)]);
            end
            if ($urandom_range(9) < 8)
                token_text.push_back(CHAR_ONE + 8'($urandom_range(4)));
            else
                token_text.push_back(CHAR_ZERO + 8'($urandom_range(9)));
            if ($urandom_range(19) == 0)
                token_text.push_back(8'($urandom_range(33, 126)));
        end
        else if (kind < 90)
        begin
            case ($urandom_range(2))
                0:
                begin
                    token_text.push_back(letters[$urandom_range(15)]);
                    token_text.push_back(CHAR_ONE + 8'($urandom_range(4)));
                end
                1:
                    push_number($urandom_range(64));
                default:
                begin
                    n = TOKEN_MAX + 1 + $urandom_range(4);
                    for (int i = 0; i < n; i++)
                        token_text.push_back(($urandom_range(1) != 0) ?
                            CHAR_ZERO + 8'($urandom_range(9)) : letters[$urandom_range(15)]);
                end
            endcase
        end
        else
        begin
            n = 1 + $urandom_range(5);
            for (int i = 0; i < n; i++)
                token_text.push_back(8'($urandom_range(255)));
        end
    endtask

    task automatic test_token_forms();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_text("8.#F5 ", 1'b0);
        send_text("999999-h7", 1'b1);
        send_char(CHAR_SPACE, 1'b1);
        send_text("#b9 ", 1'b0);
    endtask

    task automatic test_duration_limits();
        write_beat(16'hFFFF);
        send_text("1.c1 ", 1'b0);
    endtask

    task automatic test_random_melody(input int n_items, input logic [15:0] beat,
                                      input int gap_pct, input int stall_pct);
        int sent;
        int ending;
        write_beat(beat);
        send_idle_pct = gap_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items)
        begin
            build_token();
            ending = $urandom_range(99);
            foreach (token_text[i])
            begin
                send_char(token_text[i], (ending >= 80 && ending < 90) &&
                                         (i == token_text.size() - 1));
                sent++;
            end
            if (ending < 80 || ending >= 95)
            begin
                send_char(CHAR_SPACE, 1'b0);
                sent++;
                if ($urandom_range(9) == 0)
                begin
                    send_char(CHAR_SPACE, 1'b0);
                    sent++;
                end
            end
            if (ending >= 90)
            begin
                send_char(CHAR_SPACE, 1'b1);
                sent++;
            end
        end
        // close the melody so no token stays open across a beat change
        send_char(CHAR_SPACE, 1'b1);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_token_forms();
        test_duration_limits();
        test_random_melody(470, 16'd1, 0, 0);
        test_random_melody(470, 16'($urandom_range(2, 65534)), 65, 0);
        test_random_melody(470, 16'hFFFF, 0, 65);
        test_random_melody(470, 16'($urandom_range(1, 300)), 28, 28);
        s_tvalid <= 1'b0;
        while (expected_notes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d note words outstanding", expected_notes.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
